### src/rne_pkg.sv
// Shared types, step addresses and constants of the Roman numeral encoder.
package rne_pkg;

    localparam int VALUE_W = 12;
    localparam int SYM_W   = 8;
    localparam int PC_W    = 5;

    localparam logic [VALUE_W-1:0] VALUE_MAX = 12'd3999;

    // Step kinds of the control program.
    localparam logic [1:0] K_TSUB = 2'd0;  // test, and on a hit emit and subtract
    localparam logic [1:0] K_TEST = 2'd1;  // test, and on a hit emit without subtracting
    localparam logic [1:0] K_SUB  = 2'd2;  // emit and subtract unconditionally

    // Step addresses of the control program.
    localparam logic [PC_W-1:0] S_M  = 5'd0;
    localparam logic [PC_W-1:0] S_C9 = 5'd1;
    localparam logic [PC_W-1:0] S_CM = 5'd2;
    localparam logic [PC_W-1:0] S_D  = 5'd3;
    localparam logic [PC_W-1:0] S_C4 = 5'd4;
    localparam logic [PC_W-1:0] S_CD = 5'd5;
    localparam logic [PC_W-1:0] S_C  = 5'd6;
    localparam logic [PC_W-1:0] S_X9 = 5'd7;
    localparam logic [PC_W-1:0] S_XC = 5'd8;
    localparam logic [PC_W-1:0] S_L  = 5'd9;
    localparam logic [PC_W-1:0] S_X4 = 5'd10;
    localparam logic [PC_W-1:0] S_XL = 5'd11;
    localparam logic [PC_W-1:0] S_X  = 5'd12;
    localparam logic [PC_W-1:0] S_I9 = 5'd13;
    localparam logic [PC_W-1:0] S_IX = 5'd14;
    localparam logic [PC_W-1:0] S_V  = 5'd15;
    localparam logic [PC_W-1:0] S_I4 = 5'd16;
    localparam logic [PC_W-1:0] S_IV = 5'd17;
    localparam logic [PC_W-1:0] S_I  = 5'd18;

    typedef struct packed {
        logic [1:0]         kind;
        logic [VALUE_W-1:0] weight;
        logic [SYM_W-1:0]   sym;
        logic [PC_W-1:0]    hit_pc;
        logic [PC_W-1:0]    miss_pc;
    } t_uword;

endpackage

### src/roman_numeral_encoder.sv
// Top level of the Roman numeral encoder: step sequencer, datapath and output register.
//
// The input channel (i_valid, o_ready, i_value) takes one 12-bit unsigned number per
// transaction. The output channel (o_valid, i_ready) returns the numeral as a run of
// ASCII characters on o_symbol, most significant first, with o_last marking the final
// character. A value of zero returns nothing. A value above 3999 returns a single
// transaction with o_symbol zero and both o_last and o_out_of_range set.
//
// A small control program in a read-only table walks the values 1000, 900, 500 and so
// on down to 1. Each test step compares the remainder with its weight and, on a hit,
// emits a character and may subtract. One step runs per cycle while the receiver keeps
// up. After its acceptance a number takes one step per character and one step for each
// step that finds nothing to emit (at most twelve); the worst case is 3333, with 24 steps.
// The next number is accepted once the last character has left the output register or is
// being taken. The error result is loaded straight into the output register in the
// accepting cycle.
//
// When the receiver stalls, the output register holds its character and the sequencer
// waits on the same step. Reset, synchronous and active low, empties the output
// register and returns the sequencer to idle; no numeral in flight survives it.
module roman_numeral_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [11:0] i_value,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_symbol,
    output logic        o_last,
    output logic        o_out_of_range
);
    import rne_pkg::*;

    // Sequencer state: busy flag, step counter and the remainder still to be written.
    logic               r_busy, n_busy;
    logic [PC_W-1:0]    r_pc, n_pc;
    logic [VALUE_W-1:0] r_rest, n_rest;

    // Output register.
    logic               r_out_valid, n_out_valid;
    logic [SYM_W-1:0]   r_sym, n_sym;
    logic               r_last, n_last;
    logic               r_oor, n_oor;

    t_uword             uword;
    logic               slot_free;
    logic               advance;
    logic               hit;
    logic               emit;
    logic               subtract;
    logic [VALUE_W-1:0] diff;
    logic               accept;

    rne_ucode_rom u_rom (
        .i_pc    (r_pc),
        .o_uword (uword)
    );

    // The output register can take a new character when it is empty or being emptied.
    assign slot_free = !r_out_valid || i_ready;
    assign advance   = r_busy && slot_free;
    assign o_ready   = !r_busy && slot_free;
    assign accept    = i_valid && o_ready;

    assign hit      = (uword.kind == K_SUB) || (r_rest >= uword.weight);
    assign emit     = advance && hit;
    assign subtract = emit && (uword.kind != K_TEST);
    assign diff     = r_rest - uword.weight;

    always_comb begin
        n_busy      = r_busy;
        n_pc        = r_pc;
        n_rest      = r_rest;
        n_out_valid = r_out_valid && !i_ready;
        n_sym       = r_sym;
        n_last      = r_last;
        n_oor       = r_oor;

        if (accept) begin
            if (i_value > VALUE_MAX) begin
                // Out of range: a single error transaction and no numeral.
                n_out_valid = 1'b1;
                n_sym       = '0;
                n_last      = 1'b1;
                n_oor       = 1'b1;
            end else if (i_value != '0) begin
                n_busy = 1'b1;
                n_pc   = S_M;
                n_rest = i_value;
            end
        end

        if (advance) begin
            if (emit) begin
                n_out_valid = 1'b1;
                n_sym       = uword.sym;
                n_oor       = 1'b0;
                n_last      = subtract && (diff == '0);
                n_pc        = uword.hit_pc;
            end else begin
                n_pc = uword.miss_pc;
            end
            if (subtract) begin
                n_rest = diff;
                // The numeral is complete once nothing remains to be written.
                if (diff == '0) begin
                    n_busy = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_out_valid <= n_out_valid;
        end
        r_pc   <= n_pc;
        r_rest <= n_rest;
        r_sym  <= n_sym;
        r_last <= n_last;
        r_oor  <= n_oor;
    end

    assign o_valid        = r_out_valid;
    assign o_symbol       = r_sym;
    assign o_last         = r_last;
    assign o_out_of_range = r_oor;

`ifndef SYNTH
    // An error transaction is always a lone, marked result with a zero symbol.
    a_error_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_of_range) |-> (o_last && (o_symbol == '0)))
        else $error("error result without last mark or with a non-zero symbol");

    // While a numeral is in progress something always remains to be written.
    a_rest_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_rest != '0))
        else $error("sequencer busy with nothing left to write");

    // The character marked last ends the numeral and leaves the sequencer idle.
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit && subtract && (diff == '0)) |=> (!r_busy && o_valid && o_last))
        else $error("final character did not end the numeral");
`endif

endmodule

### src/rne_ucode_rom.sv
// Read-only control program of the Roman numeral encoder: one control word per step.
module rne_ucode_rom (
    input  logic [rne_pkg::PC_W-1:0] i_pc,
    output rne_pkg::t_uword          o_uword
);
    import rne_pkg::*;

    function automatic t_uword mk(input logic [1:0] kind, input logic [VALUE_W-1:0] weight,
                                  input logic [SYM_W-1:0] sym, input logic [PC_W-1:0] hit_pc,
                                  input logic [PC_W-1:0] miss_pc);
        t_uword w;
        w.kind    = kind;
        w.weight  = weight;
        w.sym     = sym;
        w.hit_pc  = hit_pc;
        w.miss_pc = miss_pc;
        return w;
    endfunction

    // Lower decades test nine, five and four units before repeating the one-symbol.
    always_comb begin
        case (i_pc)
            S_M:     o_uword = mk(K_TSUB, 12'd1000, "M", S_M,  S_C9);
            S_C9:    o_uword = mk(K_TEST, 12'd900,  "C", S_CM, S_D);
            S_CM:    o_uword = mk(K_SUB,  12'd900,  "M", S_X9, S_X9);
            S_D:     o_uword = mk(K_TSUB, 12'd500,  "D", S_C,  S_C4);
            S_C4:    o_uword = mk(K_TEST, 12'd400,  "C", S_CD, S_C);
            S_CD:    o_uword = mk(K_SUB,  12'd400,  "D", S_X9, S_X9);
            S_C:     o_uword = mk(K_TSUB, 12'd100,  "C", S_C,  S_X9);
            S_X9:    o_uword = mk(K_TEST, 12'd90,   "X", S_XC, S_L);
            S_XC:    o_uword = mk(K_SUB,  12'd90,   "C", S_I9, S_I9);
            S_L:     o_uword = mk(K_TSUB, 12'd50,   "L", S_X,  S_X4);
            S_X4:    o_uword = mk(K_TEST, 12'd40,   "X", S_XL, S_X);
            S_XL:    o_uword = mk(K_SUB,  12'd40,   "L", S_I9, S_I9);
            S_X:     o_uword = mk(K_TSUB, 12'd10,   "X", S_X,  S_I9);
            S_I9:    o_uword = mk(K_TEST, 12'd9,    "I", S_IX, S_V);
            S_IX:    o_uword = mk(K_SUB,  12'd9,    "X", S_I,  S_I);
            S_V:     o_uword = mk(K_TSUB, 12'd5,    "V", S_I,  S_I4);
            S_I4:    o_uword = mk(K_TEST, 12'd4,    "I", S_IV, S_I);
            S_IV:    o_uword = mk(K_SUB,  12'd4,    "V", S_I,  S_I);
            S_I:     o_uword = mk(K_TSUB, 12'd1,    "I", S_I,  S_I);
            default: o_uword = mk(K_TSUB, 12'd1,    "I", S_I,  S_I);
        endcase
    end

endmodule

### tb/roman_numeral_encoder_test.sv
// Self-checking testbench of the Roman numeral encoder, with its scoreboard and stimulus.
module roman_numeral_encoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rne_pkg::*;

    // Half period, reset length, quiet time covering the longest numeral, and run sizes.
    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 235;
    localparam int HOLDOFF_LEN   = 300;
    localparam int REPORT_LIMIT  = 10;

    // Symbols of each decimal position, thousands first. The thousands position only
    // ever needs its unit symbol, so its five and ten entries are never used.
    localparam int DIGIT_WEIGHT [4] = '{1000, 100, 10, 1};
    localparam logic [SYM_W-1:0] UNIT_SYM [4] = '{"M", "C", "X", "I"};
    localparam logic [SYM_W-1:0] FIVE_SYM [4] = '{8'h00, "D", "L", "V"};
    localparam logic [SYM_W-1:0] TEN_SYM  [4] = '{8'h00, "M", "C", "X"};

    // One character of the output stream, as the scoreboard expects to see it.
    typedef struct packed {
        logic [SYM_W-1:0] symbol;
        logic             last;
        logic             out_of_range;
    } t_numeral_char;

    // The scoreboard predicts the numeral of every accepted number and compares each
    // character that leaves the block with the oldest character still owed.
    class roman_scoreboard;
        t_numeral_char owed_chars[$];
        int            failures;

        function t_numeral_char glyph(input logic [SYM_W-1:0] symbol, input logic last);
            t_numeral_char c;
            c.symbol       = symbol;
            c.last         = last;
            c.out_of_range = 1'b0;
            return c;
        endfunction

        function void note_value(input logic [VALUE_W-1:0] value);
            logic [SYM_W-1:0] letters[$];
            t_numeral_char    err;
            int               rest;
            int               digit;
            rest = int'(value);
            if (value > VALUE_MAX) begin
                err.symbol       = '0;
                err.last         = 1'b1;
                err.out_of_range = 1'b1;
                owed_chars.push_back(err);
                return;
            end
            for (int pos = 0; pos < 4; pos++) begin
                digit = rest / DIGIT_WEIGHT[pos];
                rest  = rest % DIGIT_WEIGHT[pos];
                if (digit == 9) begin
                    letters.push_back(UNIT_SYM[pos]);
                    letters.push_back(TEN_SYM[pos]);
                end else if (digit >= 5) begin
                    letters.push_back(FIVE_SYM[pos]);
                    repeat (digit - 5) letters.push_back(UNIT_SYM[pos]);
                end else if (digit == 4) begin
                    letters.push_back(UNIT_SYM[pos]);
                    letters.push_back(FIVE_SYM[pos]);
                end else begin
                    repeat (digit) letters.push_back(UNIT_SYM[pos]);
                end
            end
            // Zero leaves the list empty, and so nothing is owed for it.
            foreach (letters[i]) begin
                owed_chars.push_back(glyph(letters[i], i == letters.size() - 1));
            end
        endfunction

        function void check_result(input logic [SYM_W-1:0] symbol, input logic last,
                                   input logic out_of_range);
            t_numeral_char want;
            if (owed_chars.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("%0t: unexpected character: symbol %h last %b range %b",
                             $realtime, symbol, last, out_of_range);
                end
                return;
            end
            want = owed_chars.pop_front();
            if (symbol !== want.symbol || last !== want.last
                || out_of_range !== want.out_of_range) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("%0t: mismatch: expected symbol %h last %b range %b, got %h %b %b",
                             $realtime, want.symbol, want.last, want.out_of_range,
                             symbol, last, out_of_range);
                end
            end
        endfunction

        function int pending();
            return owed_chars.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_ready;
    logic [VALUE_W-1:0] i_value;
    logic               o_valid;
    logic               i_ready;
    logic [SYM_W-1:0]   o_symbol;
    logic               o_last;
    logic               o_out_of_range;

    roman_scoreboard board;

    // A request from the stimulus for the receiver to stop taking characters for a
    // long stretch; the receiver counts the stretch out in its own process.
    int holdoff_request;

    roman_numeral_encoder u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_symbol       (o_symbol),
        .o_last         (o_last),
        .o_out_of_range (o_out_of_range)
    );

    initial i_clk = 1'b0;
    always #(HALF_PERIOD) i_clk = ~i_clk;

    // Inputs only ever change at the falling edge. At the rising edge the testbench
    // reads the values from before the edge, as the block's registers update later in
    // the same time step, so each transaction is seen exactly as the block sees it.

    // Offers one number and holds it until the transaction completes. The valid line
    // is left high on return, so that a following number in the same burst is
    // offered without a gap.
    task automatic send_value(input logic [VALUE_W-1:0] value);
        i_valid = 1'b1;
        i_value = value;
        do @(posedge i_clk); while (!o_ready);
        board.note_value(value);
        @(negedge i_clk);
    endtask

    // Withdraws the offer for the given number of cycles, with junk on the value bus.
    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            i_valid = 1'b0;
            i_value = VALUE_W'($urandom);
            repeat (cycles) @(negedge i_clk);
        end
    endtask

    // Waits until every character owed has arrived, then lets the block settle, so
    // that nothing unexpected follows the last character.
    task automatic drain_block();
        idle_sender(1);
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Random numbers: mostly valid ones, with a share built from the digits that give
    // the longest or the subtractive patterns, plus errors, zeros and raw bit patterns.
    function automatic logic [VALUE_W-1:0] random_value();
        int pick;
        int digits [4];
        pick = $urandom_range(0, 9);
        case (pick)
            0: return VALUE_W'($urandom_range(4000, 4095));
            1: return '0;
            2: return VALUE_W'($urandom);
            3, 4: begin
                digits[0] = $urandom_range(0, 3);
                for (int i = 1; i < 4; i++) begin
                    case ($urandom_range(0, 3))
                        0: digits[i] = 3;
                        1: digits[i] = 4;
                        2: digits[i] = 8;
                        default: digits[i] = 9;
                    endcase
                end
                return VALUE_W'(digits[0] * 1000 + digits[1] * 100 + digits[2] * 10
                                + digits[3]);
            end
            default: return VALUE_W'($urandom_range(1, 3999));
        endcase
    endfunction

    // The receiver cycles through phases of its own: always ready, ready about half
    // the time, ready about one cycle in four, and a fixed stutter. A long hold-off
    // from the stimulus overrides the phase until it has been counted out.
    initial begin
        int rx_cycle;
        int hold_left;
        rx_cycle  = 0;
        hold_left = 0;
        i_ready   = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_request > 0) begin
                hold_left       = holdoff_request;
                holdoff_request = 0;
            end
            if (hold_left > 0) begin
                i_ready = 1'b0;
                hold_left--;
            end else begin
                case ((rx_cycle / 64) % 4)
                    0: i_ready = 1'b1;
                    1: i_ready = $urandom_range(0, 1) == 1;
                    2: i_ready = $urandom_range(0, 3) == 0;
                    default: i_ready = (rx_cycle % 8) != 0 && (rx_cycle % 8) != 5;
                endcase
            end
            rx_cycle++;
        end
    end

    // Every character that completes a transaction on the output side is checked.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            board.check_result(o_symbol, o_last, o_out_of_range);
        end
    end

    // Stimulus: reset, a directed set of numbers, then random bursts.
    initial begin
        logic [VALUE_W-1:0] directed [$];
        int burst_left;
        board           = new();
        holdoff_request = 0;
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_value         = '0;
        burst_left      = 0;

        // The first entries are the extremes: zero, one, the largest valid number,
        // the smallest and largest errors, and the longest numeral. Then the four, nine and
        // five patterns in each lower position follow, along with alternating bit patterns.
        directed = '{12'd0, 12'd1, 12'd3999, 12'd4000, 12'd4095, 12'd3888,
                     12'd4, 12'd9, 12'd5, 12'd8, 12'd40, 12'd90, 12'd50, 12'd400,
                     12'd900, 12'd500, 12'd1000, 12'd1994, 12'd2730, 12'd1365,
                     12'd2048, 12'd4094, 12'd3, 12'd0, 12'd777};

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed numbers go in with short random gaps between them.
        foreach (directed[i]) begin
            send_value(directed[i]);
            idle_sender($urandom_range(0, 3));
        end
        drain_block();

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            // A long hold-off on the output side while numbers keep arriving back to
            // back, so that the output register fills and the input side stalls.
            if (n == 100) begin
                holdoff_request = HOLDOFF_LEN;
                burst_left      = 25;
            end
            // Partway through, the sender stops until the block is empty.
            if (n == 180) begin
                drain_block();
                burst_left = 0;
            end
            if (burst_left == 0) begin
                idle_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
                burst_left = $urandom_range(1, 16);
            end
            send_value(random_value());
            burst_left--;
        end

        idle_sender(1);
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        if (board.failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, including the hold-off.
    initial begin
        #4_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
